// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the swing level tracker.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, idle while reset is asserted (active-low reset).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/dslt_pkg.sv
// Package for the dynamic swing level tracker: beat types, register
// indexes and the threshold tables. No dependencies.
package dslt_pkg;

  // Input beat: one amplitude and one phase sample.
  typedef struct packed {
    logic [7:0] amp_sample;
    logic [7:0] phase_sample;
  } dslt_in_t;

  // Result beat: three indicator codes.
  typedef struct packed {
    logic [3:0] amp_level;
    logic [4:0] phase_level;
    logic [3:0] swing_level;
  } dslt_out_t;

  // Register indexes (byte address bit 2 selects the register).
  typedef enum logic {
    REG_AMP_BASELINE   = 1'b0,
    REG_PHASE_BASELINE = 1'b1
  } dslt_reg_e;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Signed deviation width: covers -255..255 and the threshold offsets.
  localparam int unsigned DevW = 10;

  // Upper thresholds for phase and peak swing, farthest first.
  localparam logic signed [DevW-1:0] STEP_T [8] = '{
    10'sd92, 10'sd81, 10'sd70, 10'sd59, 10'sd48, 10'sd37, 10'sd26, 10'sd15
  };
  // Amplitude upper thresholds, farthest first.
  localparam logic signed [DevW-1:0] AMP_UP_T [7] = '{
    10'sd92, 10'sd81, 10'sd70, 10'sd59, 10'sd48, 10'sd37, 10'sd26
  };
  // Amplitude lower thresholds, nearest first (below the near band).
  localparam logic signed [DevW-1:0] AMP_DN_T [5] = '{
    10'sd37, 10'sd48, 10'sd59, 10'sd70, 10'sd81
  };
  localparam logic signed [DevW-1:0] AMP_NEAR_T = 10'sd26;
  // Trough thresholds, nearest first.
  localparam logic signed [DevW-1:0] LOW_T [8] = '{
    10'sd5, 10'sd15, 10'sd26, 10'sd37, 10'sd48, 10'sd59, 10'sd70, 10'sd81
  };

endpackage

// File: hw/rtl/dynamic_swing_level_tracker.sv
// Dynamic swing level tracker top level: input register, peak state,
// level coding and result register. Depends on dslt_pkg, dslt_level_calc.
// Flow: a beat is taken into the input register, then coded into the result
// register and shown on out_data_o. One beat per cycle unless out_stall_i
// holds the pipeline; peak and trough update from their own registers per beat.
// Reset (async, active low) clears both baselines, peak and trough to zero
// and empties the pipeline; no clearing pass is needed.
`include "assert_macros.svh"
module dynamic_swing_level_tracker import dslt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dslt_in_t            in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dslt_out_t           out_data_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [7:0] amp_baseline_q, phase_baseline_q;
  logic [7:0] peak_high_q, peak_low_q, peak_high_d, peak_low_d;
  logic       s1_valid_q, out_valid_q;
  dslt_in_t   s1_data_q;
  dslt_out_t  out_q, result_d;
  logic       out_free, s1_fire, in_fire, cfg_wr;
  dslt_reg_e  reg_sel;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = dslt_reg_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_baseline_q   <= '0;
      phase_baseline_q <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_AMP_BASELINE:   amp_baseline_q   <= pwdata[7:0];
        REG_PHASE_BASELINE: phase_baseline_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AMP_BASELINE:   prdata = {{(ApbDataW-8){1'b0}}, amp_baseline_q};
      REG_PHASE_BASELINE: prdata = {{(ApbDataW-8){1'b0}}, phase_baseline_q};
      default:            prdata = '0;
    endcase
  end

  // Pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  dslt_level_calc u_calc (
    .sample_i     (s1_data_q),
    .amp_base_i   (amp_baseline_q),
    .phase_base_i (phase_baseline_q),
    .peak_high_i  (peak_high_q),
    .peak_low_i   (peak_low_q),
    .peak_high_o  (peak_high_d),
    .peak_low_o   (peak_low_d),
    .result_o     (result_d)
  );

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      peak_high_q <= '0;
      peak_low_q  <= '0;
    end else begin
      if (out_free) out_valid_q <= s1_valid_q;
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (s1_fire) begin
        peak_high_q <= peak_high_d;
        peak_low_q  <= peak_low_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q <= in_data_i;
    if (s1_fire) out_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `ASSERT_CLK(a_clamp, clk_i, rst_ni,
    s1_fire |=> (peak_high_q >= $past(amp_baseline_q)) && (peak_low_q <= $past(amp_baseline_q)),
    "peak or trough not clamped to baseline")
  `ASSERT_CLK(a_fire_out, clk_i, rst_ni, s1_fire |=> out_valid_q,
    "processed beat lost before result register")
  `ASSERT_CLK(a_stall_src, clk_i, rst_ni,
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i),
    "input stalled without a full pipeline")
  `ASSERT_CLK(a_ranges, clk_i, rst_ni,
    out_valid_q |-> (out_q.amp_level <= 4'd14) && (out_q.phase_level <= 5'd16) &&
      (out_q.swing_level <= 4'd8),
    "result code out of range")
  `ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> (!out_valid_o && !in_stall_o),
    "pipeline not empty in reset")

endmodule

// File: hw/rtl/dslt_level_calc.sv
// Peak/trough update and level coding for one sample beat.
// Purely combinational; depends on dslt_pkg.
module dslt_level_calc import dslt_pkg::*; (
  input  dslt_in_t   sample_i,
  input  logic [7:0] amp_base_i,
  input  logic [7:0] phase_base_i,
  input  logic [7:0] peak_high_i,
  input  logic [7:0] peak_low_i,
  output logic [7:0] peak_high_o,
  output logic [7:0] peak_low_o,
  output dslt_out_t  result_o
);

  logic [7:0]            amp, hi_n, lo_n, hi_dec, lo_inc;
  logic                  decay;
  logic signed [DevW-1:0] amp_dev, ph_dev, hi_dev, lo_dev;

  assign amp = sample_i.amp_sample;

  // Saturating one-step decay toward the baseline
  assign hi_dec = (peak_high_i != 8'd0)   ? peak_high_i - 8'd1 : peak_high_i;
  assign lo_inc = (peak_low_i  != 8'hff)  ? peak_low_i + 8'd1  : peak_low_i;

  // Follow a new extreme, otherwise decay both
  always_comb begin
    hi_n  = peak_high_i;
    lo_n  = peak_low_i;
    decay = 1'b0;
    if (amp >= amp_base_i) begin
      if (amp >= peak_high_i) hi_n = amp;
      else decay = 1'b1;
    end else begin
      if (amp < peak_low_i) lo_n = amp;
      else decay = 1'b1;
    end
    if (decay) begin
      hi_n = hi_dec;
      lo_n = lo_inc;
    end
    // clamp both to the baseline
    if (hi_n < amp_base_i) hi_n = amp_base_i;
    if (lo_n > amp_base_i) lo_n = amp_base_i;
  end

  assign peak_high_o = hi_n;
  assign peak_low_o  = lo_n;

  // Signed deviations from the baselines
  assign amp_dev = $signed({2'b00, amp}) - $signed({2'b00, amp_base_i});
  assign ph_dev  = $signed({2'b00, sample_i.phase_sample}) - $signed({2'b00, phase_base_i});
  assign hi_dev  = $signed({2'b00, hi_n}) - $signed({2'b00, amp_base_i});
  assign lo_dev  = $signed({2'b00, amp_base_i}) - $signed({2'b00, lo_n});

  // Priority coders: later assignments win, so the tests run from lowest
  // to highest priority.
  always_comb begin
    logic [3:0] amp_code;
    logic [4:0] ph_code;
    logic [3:0] sw_code;

    // amplitude
    amp_code = 4'd1;
    for (int i = 4; i >= 0; i--) begin
      if (amp_dev > -AMP_DN_T[i]) amp_code = 4'(6 - i);
    end
    if (amp_dev > -AMP_NEAR_T) amp_code = 4'd7;
    if (amp_dev > 10'sd0) amp_code = 4'd0;
    for (int i = 6; i >= 0; i--) begin
      if (amp_dev > AMP_UP_T[i]) amp_code = 4'(14 - i);
    end

    // phase
    ph_code = 5'd1;
    for (int i = 6; i >= 0; i--) begin
      if (ph_dev > -STEP_T[7 - i]) ph_code = 5'(8 - i);
    end
    if (ph_dev > 10'sd0) ph_code = 5'd0;
    for (int i = 7; i >= 0; i--) begin
      if (ph_dev > STEP_T[i]) ph_code = 5'(16 - i);
    end

    // swing from the larger excursion
    if (lo_dev < hi_dev) begin
      sw_code = 4'd0;
      for (int i = 7; i >= 0; i--) begin
        if (hi_dev > STEP_T[i]) sw_code = 4'(8 - i);
      end
    end else begin
      sw_code = 4'd8;
      for (int i = 7; i >= 0; i--) begin
        if (-lo_dev > -LOW_T[i]) sw_code = 4'(i);
      end
    end

    result_o.amp_level   = amp_code;
    result_o.phase_level = ph_code;
    result_o.swing_level = sw_code;
  end

endmodule

// File: bench/tb_dynamic_swing_level_tracker.sv
// Self-checking bench for the dynamic swing level tracker: sample beats are
// scored against an in-bench model of the peak/trough tracking and level coding.
// Depends on dslt_pkg and the dynamic_swing_level_tracker RTL.
module tb_dynamic_swing_level_tracker;
  import dslt_pkg::*;

  localparam int CycleLimit = 200000;
  // Upper steps (phase, peak swing, amplitude above) and trough steps, nearest last/first.
  localparam int UpStep[8]     = '{92, 81, 70, 59, 48, 37, 26, 15};
  localparam int TroughStep[8] = '{5, 15, 26, 37, 48, 59, 70, 81};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  dslt_in_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  dslt_out_t           out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  dynamic_swing_level_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state: baselines as last written, decaying peak and trough.
  int amp_base_m = 0;
  int ph_base_m  = 0;
  int trk_hi     = 0;
  int trk_lo     = 0;

  dslt_in_t  pending_beats[$];
  dslt_out_t expected_levels[$];
  int        idle_mode = 0;
  int        in_gap = 0;
  int        stall_left = 0;
  bit        in_fire = 1'b0;
  int        fail_count = 0;
  int        beats_in = 0;
  int        results_seen = 0;
  int        settings_run = 0;
  int        cycle_count = 0;

  function automatic logic [7:0] clip8(int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic dslt_in_t beat_of(int a, int f);
    dslt_in_t b;
    b.amp_sample   = clip8(a);
    b.phase_sample = clip8(f);
    return b;
  endfunction

  // Idle length: mode 0 never idles; otherwise mostly none or short, some long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (r < ((idle_mode == 1) ? 65 : 35)) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [3:0] amp_code(int a, int b);
    for (int i = 0; i < 7; i++)
      if (a > b + UpStep[i]) return 4'(14 - i);
    if (a > b) return 4'd0;
    if (a > b - 26) return 4'd7;
    for (int i = 0; i < 5; i++)
      if (a > b - TroughStep[i + 3]) return 4'(6 - i);
    return 4'd1;
  endfunction

  function automatic logic [4:0] phase_code(int f, int b);
    for (int i = 0; i < 8; i++)
      if (f > b + UpStep[i]) return 5'(16 - i);
    if (f > b) return 5'd0;
    for (int i = 0; i < 7; i++)
      if (f > b - UpStep[7 - i]) return 5'(8 - i);
    return 5'd1;
  endfunction

  // Swing from whichever of peak or trough sits farther from the baseline.
  function automatic logic [3:0] swing_code(int hi, int lo, int b);
    if ((b - lo) < (hi - b)) begin
      for (int i = 0; i < 8; i++)
        if (hi > b + UpStep[i]) return 4'(8 - i);
      return 4'd0;
    end
    for (int i = 0; i < 8; i++)
      if (lo > b - TroughStep[i]) return 4'(i);
    return 4'd8;
  endfunction

  // One step toward the baseline, saturating at the byte limits.
  function automatic void decay_peaks();
    if (trk_hi > 0) trk_hi--;
    if (trk_lo < 255) trk_lo++;
  endfunction

  function automatic dslt_out_t predict_levels(dslt_in_t beat);
    dslt_out_t r;
    int a;
    a = beat.amp_sample;
    if (a >= amp_base_m) begin
      if (a >= trk_hi) trk_hi = a;
      else decay_peaks();
    end else begin
      if (a < trk_lo) trk_lo = a;
      else decay_peaks();
    end
    if (trk_hi < amp_base_m) trk_hi = amp_base_m;
    if (trk_lo > amp_base_m) trk_lo = amp_base_m;
    r.amp_level   = amp_code(a, amp_base_m);
    r.phase_level = phase_code(beat.phase_sample, ph_base_m);
    r.swing_level = swing_code(trk_hi, trk_lo, amp_base_m);
    return r;
  endfunction

  // Sample driver: holds a beat until taken, then waits out a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap > 0 || pending_beats.size() == 0) begin
        in_valid_i <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_beats.pop_front();
        in_gap = gap_len();
      end
    end
  end

  // Result-side back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  // Monitor: predict on each accepted sample beat, score each result beat.
  always @(posedge clk_i) begin
    dslt_out_t exp_l;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      expected_levels.push_back(predict_levels(in_data_i));
      beats_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_levels.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data_o);
        fail_count++;
      end else begin
        exp_l = expected_levels.pop_front();
        if (out_data_o.amp_level !== exp_l.amp_level) begin
          $error("amp_level: expected %0d, got %0d", exp_l.amp_level, out_data_o.amp_level);
          fail_count++;
        end
        if (out_data_o.phase_level !== exp_l.phase_level) begin
          $error("phase_level: expected %0d, got %0d",
                 exp_l.phase_level, out_data_o.phase_level);
          fail_count++;
        end
        if (out_data_o.swing_level !== exp_l.swing_level) begin
          $error("swing_level: expected %0d, got %0d",
                 exp_l.swing_level, out_data_o.swing_level);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_levels.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // APB write; upper data bits carry junk that the register must drop.
  task automatic apb_write(input dslt_reg_e idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(input dslt_reg_e idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== ApbDataW'(val)) begin
      $error("prdata of %s: expected %0d, got %0d", idx.name(), val, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_baselines(input int amp_b, input int ph_b);
    apb_write(REG_AMP_BASELINE, 8'(amp_b));
    apb_write(REG_PHASE_BASELINE, 8'(ph_b));
    amp_base_m = amp_b;
    ph_base_m  = ph_b;
    apb_check(REG_AMP_BASELINE, 8'(amp_b));
    apb_check(REG_PHASE_BASELINE, 8'(ph_b));
    settings_run++;
  endtask

  // Wait until every queued beat has gone in and every result has come out.
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random sample: uniform noise, jitter around the baseline, or a spike
  // followed naturally by quieter beats so the peak and trough decay.
  function automatic dslt_in_t rand_beat();
    int k, a, f;
    k = $urandom_range(0, 9);
    if (k < 3) a = $urandom_range(0, 255);
    else if (k < 7) a = amp_base_m + $urandom_range(0, 24) - 12;
    else a = amp_base_m + $urandom_range(0, 260) - 130;
    if ($urandom_range(0, 2) == 0) f = ph_base_m + $urandom_range(0, 200) - 100;
    else f = $urandom_range(0, 255);
    return beat_of(a, f);
  endfunction

  task automatic run_phase(input int amp_b, input int ph_b, input int n, input int mode);
    set_baselines(amp_b, ph_b);
    idle_mode = mode;
    for (int i = 0; i < n; i++) pending_beats.push_back(rand_beat());
    drain();
  endtask

  initial begin
    // falling edge on reset at time zero so the async reset takes effect
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: threshold edges at a mid baseline, field extremes, decay runs.
    set_baselines(128, 128);
    idle_mode = 1;
    pending_beats.push_back(beat_of(128, 128));
    pending_beats.push_back(beat_of(129, 129));
    pending_beats.push_back(beat_of(127, 127));
    pending_beats.push_back(beat_of(255, 255));
    pending_beats.push_back(beat_of(128, 0));
    pending_beats.push_back(beat_of(128, 128));
    pending_beats.push_back(beat_of(0, 0));
    pending_beats.push_back(beat_of(220, 143));
    pending_beats.push_back(beat_of(221, 144));
    pending_beats.push_back(beat_of(47, 113));
    pending_beats.push_back(beat_of(46, 112));
    pending_beats.push_back(beat_of(102, 47));
    pending_beats.push_back(beat_of(103, 46));
    pending_beats.push_back(beat_of(154, 221));
    pending_beats.push_back(beat_of(155, 220));
    pending_beats.push_back(beat_of(91, 36));
    pending_beats.push_back(beat_of(90, 37));
    pending_beats.push_back(beat_of(123, 170));
    pending_beats.push_back(beat_of(124, 85));
    for (int i = 0; i < 5; i++) pending_beats.push_back(beat_of(128, 128 + i));
    drain();

    // Extreme baselines, including switches that leave the trackers off-range.
    run_phase(0, 0, 30, 0);
    run_phase(255, 255, 30, 1);
    run_phase(0, 255, 30, 2);
    run_phase(255, 0, 30, 1);
    for (int p = 0; p < 6; p++)
      run_phase($urandom_range(0, 255), $urandom_range(0, 255), 55, p % 3);

    repeat (10) @(posedge clk_i);
    $display("%0d sample beats in, %0d level results checked", beats_in, results_seen);
    $display("%0d baseline settings, extremes and random, with idle and stall gaps",
             settings_run);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
